// File: rtl/mts_pkg.sv
`timescale 1ns / 1ps
// mts_pkg: shared constants, request/status codes and transaction structs
// for the max tracking stack; no dependencies

package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY   = 2'd1;
  localparam logic [1:0] ST_QUERY_EMPTY = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] max_value;
  } out_res_t;

endpackage

// File: rtl/mts_ram.sv
`timescale 1ns / 1ps
// mts_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependencies

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/max_tracking_stack.sv
`timescale 1ns / 1ps
// max_tracking_stack: bounded lifo of signed values with a maximum query
// depends on mts_pkg and mts_ram

// A transaction is taken at a rising edge with start high and busy low, and
// its single result shows on out_data for exactly one cycle, flagged by
// out_valid, in the cycle after acceptance; the receiver cannot stall, so
// every result must be captured when out_valid is high. Push and query may
// follow back to back. A pop that leaves at least one entry also sets busy,
// which is high for one cycle while the new top's running maximum is read
// back from the running-max ram (one read port, registered read data).
// Pops on an empty stack, pops down to zero entries, pushes on a full stack
// and the unused request code leave busy low. The maximum returned for a
// query is the running maximum of the top entry, so no walk of the stack is
// ever needed. No clearing pass is needed after reset.

module max_tracking_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mts_pkg::in_req_t  in_data,
  output logic              out_valid,
  output mts_pkg::out_res_t out_data
);

  localparam int VW    = mts_pkg::VALUE_WIDTH;
  localparam int AW    = mts_pkg::ADDR_W;
  localparam int CW    = mts_pkg::CNT_W;
  localparam int DEPTH = mts_pkg::STACK_DEPTH;

  // control state
  logic [CW-1:0]     count_r, count_nxt;
  logic              refill_r, refill_nxt;
  logic              out_valid_r, out_valid_nxt;
  // payload state
  logic signed [VW-1:0] top_max_r, top_max_nxt;   // running max of top entry
  mts_pkg::out_res_t    out_data_r, out_data_nxt;

  // ram ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic signed [VW-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VW-1:0]        ram_rdata;

  logic                 accept;
  logic                 empty;
  logic                 full;
  logic signed [VW-1:0] push_v;
  logic [CW-1:0]        count_m2;

  assign busy      = refill_r;
  assign accept    = start && !refill_r;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(DEPTH));
  // sign-extend or truncate the 32-bit field to the stored width
  assign push_v    = VW'(in_data.push_value);
  assign count_m2  = count_r - CW'(2);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // running maxima; the value column itself is never read back, so only
  // the running max is stored
  mts_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_max_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    count_nxt     = count_r;
    refill_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    top_max_nxt   = top_max_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = push_v;
    ram_raddr     = count_m2[AW-1:0];

    // pop refill: new top running max arrives from the ram
    if (refill_r) begin
      top_max_nxt = ram_rdata;
    end

    if (accept) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.status    = mts_pkg::ST_OK;
      out_data_nxt.max_value = '0;
      case (in_data.req_type)
        mts_pkg::REQ_PUSH: begin
          if (full) begin
            out_data_nxt.status = mts_pkg::ST_PUSH_FULL;
          end else begin
            if (empty || (push_v > top_max_r)) begin
              top_max_nxt = push_v;
            end
            ram_we    = 1'b1;
            ram_wdata = (empty || (push_v > top_max_r)) ? push_v : top_max_r;
            count_nxt = count_r + CW'(1);
          end
        end
        mts_pkg::REQ_POP: begin
          if (empty) begin
            out_data_nxt.status = mts_pkg::ST_POP_EMPTY;
          end else begin
            count_nxt = count_r - CW'(1);
            // entries remain: fetch the running max below the old top
            if (count_r >= CW'(2)) begin
              refill_nxt = 1'b1;
            end
          end
        end
        mts_pkg::REQ_QUERY: begin
          if (empty) begin
            out_data_nxt.status = mts_pkg::ST_QUERY_EMPTY;
          end else begin
            out_data_nxt.max_value = 32'(top_max_r);
          end
        end
        default: begin
          // unused code: no change, ok with zero
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      refill_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      refill_r    <= refill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_max_r  <= top_max_nxt;
    out_data_r <= out_data_nxt;
  end

  // a refill only follows an accepted pop
  a_refill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    refill_r |-> $past(accept && (in_data.req_type == mts_pkg::REQ_POP)))
    else $error("refill without a preceding pop");

  // every accepted transaction gives exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(accept)) |-> out_valid_r)
    else $error("accepted transaction without a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(accept))
    else $error("result without an accepted transaction");

  // the stack never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count over depth");

  // a dropped push is reported only when the stack was full
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == mts_pkg::ST_PUSH_FULL))
      |-> ($past(count_r) == CW'(DEPTH)))
    else $error("push reported full on a stack that was not full");

endmodule
